>>> rtl/rbip_pkg.sv
// Shared types, constants and codes for the relay bank controller.
package rbip_pkg;

    localparam int CHANNELS   = 4;
    localparam int IDX_W      = $clog2(CHANNELS);
    localparam int COUNT_W    = 3;
    localparam int CHAN_ID_W  = 8;
    localparam int GROUP_W    = 8;
    localparam int PULSE_W    = 32;
    localparam int STAGGER_W  = 16;
    localparam int SAVE_W     = 10;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [SAVE_W-1:0]  SAVE_DELAY = SAVE_W'(1000);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = COUNT_W'(CHANNELS);

    typedef enum logic [2:0] {
        MODE_TICK        = 3'd0,
        MODE_SET         = 3'd1,
        MODE_TOGGLE      = 3'd2,
        MODE_SET_ALL     = 3'd3,
        MODE_BATCH_START = 3'd4,
        MODE_BATCH_END   = 3'd5
    } mode_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT    = 4'd0,
        REG_ACTIVE_LOW       = 4'd1,
        REG_STAGGER_INTERVAL = 4'd2,
        REG_INTERLOCK_GROUPS = 4'd3,
        REG_PULSE_LEN_0      = 4'd4,
        REG_PULSE_LEN_1      = 4'd5,
        REG_PULSE_LEN_2      = 4'd6,
        REG_PULSE_LEN_3      = 4'd7
    } reg_idx_e;

    typedef struct packed {
        logic [2:0]           mode;
        logic [CHAN_ID_W-1:0] channel;
        logic                 value;
    } cmd_t;

    typedef struct packed {
        logic                accepted;
        logic [CHANNELS-1:0] pin_levels;
        logic [CHANNELS-1:0] logical_states;
        logic [CHANNELS-1:0] notify_mask;
        logic [CHANNELS-1:0] notify_values;
        logic                save_request;
        logic                stagger_busy;
    } rsp_t;

    typedef struct packed {
        logic [COUNT_W-1:0]                channel_count;
        logic                              active_low;
        logic [STAGGER_W-1:0]              stagger_interval;
        logic [CHANNELS*GROUP_W-1:0]       interlock_groups;
        logic [CHANNELS-1:0][PULSE_W-1:0]  pulse_len;
    } cfg_t;

endpackage

>>> rtl/rbip_cfg.sv
// Configuration register file, written through its own valid/ready channel.
module rbip_cfg
    import rbip_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CHANNEL_COUNT:    cfg_next.channel_count    = cfg_data[COUNT_W-1:0];
                REG_ACTIVE_LOW:       cfg_next.active_low       = cfg_data[0];
                REG_STAGGER_INTERVAL: cfg_next.stagger_interval = cfg_data[STAGGER_W-1:0];
                REG_INTERLOCK_GROUPS: cfg_next.interlock_groups =
                                          cfg_data[CHANNELS*GROUP_W-1:0];
                REG_PULSE_LEN_0:      cfg_next.pulse_len[0]     = cfg_data[PULSE_W-1:0];
                REG_PULSE_LEN_1:      cfg_next.pulse_len[1]     = cfg_data[PULSE_W-1:0];
                REG_PULSE_LEN_2:      cfg_next.pulse_len[2]     = cfg_data[PULSE_W-1:0];
                REG_PULSE_LEN_3:      cfg_next.pulse_len[3]     = cfg_data[PULSE_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count    <= COUNT_MAX;
            cfg_reg.active_low       <= 1'b1;
            cfg_reg.stagger_interval <= STAGGER_W'(100);
            cfg_reg.interlock_groups <= '0;
            cfg_reg.pulse_len        <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/rbip_core.sv
// Command register, channel state, single-pass update logic and result register.
module rbip_core
    import rbip_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    cmd_t cmd_reg;
    logic cmd_vld_reg;
    rsp_t rsp_reg;
    rsp_t rsp_next;
    logic rsp_vld_reg;
    logic proceed;
    logic fire;

    logic [CHANNELS-1:0]              logical_reg, logical_next;
    logic [CHANNELS-1:0]              drive_reg, drive_next;
    logic [CHANNELS-1:0]              pin_reg, pin_next;
    logic [CHANNELS-1:0]              armed_reg, armed_next;
    logic [CHANNELS-1:0][PULSE_W-1:0] left_reg, left_next;
    logic                             batch_reg, batch_next;
    logic                             stag_on_reg, stag_on_next;
    logic                             stag_now_reg, stag_now_next;
    logic [STAGGER_W-1:0]             stag_wait_reg, stag_wait_next;
    logic                             save_pend_reg, save_pend_next;
    logic [SAVE_W-1:0]                save_wait_reg, save_wait_next;

    logic [COUNT_W-1:0]               used_n;
    logic [CHANNELS-1:0]              use_mask;
    logic [CHANNELS-1:0][GROUP_W-1:0] grp;
    logic [CHANNELS-1:0]              later_peer;
    logic [CHANNELS-1:0]              earlier_peer;
    logic                             id_ok;
    logic [IDX_W-1:0]                 idx;
    logic                             sel_logical;
    logic                             sel_drive;
    logic [GROUP_W-1:0]               sel_grp;
    logic [PULSE_W-1:0]               sel_plen;
    logic                             new_val;
    logic                             found;
    logic                             accepted;
    logic [CHANNELS-1:0]              note_mask;
    logic [CHANNELS-1:0]              note_vals;
    logic                             save_req;

    assign proceed   = !rsp_vld_reg || rsp_ready;
    assign cmd_ready = !cmd_vld_reg || proceed;
    assign fire      = cmd_vld_reg && proceed;
    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    assign used_n = (cfg.channel_count == '0 || cfg.channel_count > COUNT_MAX)
                    ? COUNT_MAX : cfg.channel_count;
    assign id_ok  = (cmd_reg.channel != '0) && (cmd_reg.channel <= CHAN_ID_W'(used_n));
    assign idx    = IDX_W'(cmd_reg.channel - CHAN_ID_W'(1));

    always_comb
    begin
        sel_logical = 1'b0;
        sel_drive   = 1'b0;
        sel_grp     = '0;
        sel_plen    = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            use_mask[i] = (COUNT_W'(i) < used_n);
            grp[i]      = cfg.interlock_groups[GROUP_W*i +: GROUP_W];
            if (IDX_W'(i) == idx)
            begin
                sel_logical = logical_reg[i];
                sel_drive   = drive_reg[i];
                sel_grp     = cfg.interlock_groups[GROUP_W*i +: GROUP_W];
                sel_plen    = cfg.pulse_len[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            later_peer[i]   = 1'b0;
            earlier_peer[i] = 1'b0;
            for (int m = 0; m < CHANNELS; m++)
            begin
                if (use_mask[i] && use_mask[m] && grp[i] != '0 && grp[m] == grp[i])
                begin
                    if (m > i)
                        later_peer[i] = 1'b1;
                    if (m < i)
                        earlier_peer[i] = 1'b1;
                end
            end
        end
    end

    assign new_val = (cmd_reg.mode == MODE_SET) ? cmd_reg.value : !sel_logical;

    always_comb
    begin
        logical_next   = logical_reg;
        drive_next     = drive_reg;
        pin_next       = pin_reg;
        armed_next     = armed_reg;
        left_next      = left_reg;
        batch_next     = batch_reg;
        stag_on_next   = stag_on_reg;
        stag_now_next  = stag_now_reg;
        stag_wait_next = stag_wait_reg;
        save_pend_next = save_pend_reg;
        save_wait_next = save_wait_reg;
        accepted       = 1'b1;
        note_mask      = '0;
        note_vals      = '0;
        save_req       = 1'b0;
        found          = 1'b0;

        case (cmd_reg.mode)
            MODE_TICK:
            begin
                for (int i = 0; i < CHANNELS; i++)
                    if (armed_reg[i] && left_reg[i] != '0)
                        left_next[i] = left_reg[i] - PULSE_W'(1);
                if (stag_wait_reg != '0)
                    stag_wait_next = stag_wait_reg - STAGGER_W'(1);
                if (save_wait_reg != '0)
                    save_wait_next = save_wait_reg - SAVE_W'(1);

                if (stag_on_reg && (stag_now_reg || stag_wait_next == '0))
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (!found && use_mask[i] && drive_reg[i] != logical_reg[i])
                        begin
                            found         = 1'b1;
                            pin_next[i]   = logical_reg[i] ^ cfg.active_low;
                            drive_next[i] = logical_reg[i];
                        end
                    end
                    if (found)
                    begin
                        stag_now_next  = 1'b0;
                        stag_wait_next = cfg.stagger_interval;
                    end
                    else
                    begin
                        stag_on_next   = 1'b0;
                        save_req       = 1'b1;
                        save_pend_next = 1'b0;
                    end
                end

                if (!stag_on_next && save_pend_next && save_wait_next == '0)
                begin
                    save_req       = 1'b1;
                    save_pend_next = 1'b0;
                end

                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (use_mask[i] && armed_reg[i] && left_next[i] == '0)
                    begin
                        armed_next[i] = 1'b0;
                        if (batch_reg || logical_next[i] || drive_next[i])
                        begin
                            if (!batch_reg && !stag_on_next)
                            begin
                                pin_next[i]   = cfg.active_low;
                                drive_next[i] = 1'b0;
                            end
                            logical_next[i] = 1'b0;
                            left_next[i]    = '0;
                            if (!batch_reg)
                            begin
                                save_pend_next = 1'b1;
                                save_wait_next = SAVE_DELAY;
                            end
                            note_mask[i] = 1'b1;
                            note_vals[i] = 1'b0;
                        end
                    end
                end
            end

            MODE_SET, MODE_TOGGLE:
            begin
                if (!id_ok)
                begin
                    accepted = 1'b0;
                end
                else if (batch_reg || sel_logical != new_val || sel_drive != new_val)
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (IDX_W'(i) == idx)
                        begin
                            if (!batch_reg && !stag_on_reg)
                            begin
                                pin_next[i]   = new_val ^ cfg.active_low;
                                drive_next[i] = new_val;
                            end
                            logical_next[i] = new_val;
                            armed_next[i]   = new_val && sel_plen != '0;
                            left_next[i]    = new_val ? sel_plen : '0;
                            note_mask[i]    = 1'b1;
                            note_vals[i]    = new_val;
                        end
                        else if (new_val && sel_grp != '0 && use_mask[i]
                                 && grp[i] == sel_grp && logical_reg[i])
                        begin
                            pin_next[i]     = cfg.active_low;
                            logical_next[i] = 1'b0;
                            armed_next[i]   = 1'b0;
                            left_next[i]    = '0;
                        end
                    end
                    if (!batch_reg)
                    begin
                        save_pend_next = 1'b1;
                        save_wait_next = SAVE_DELAY;
                    end
                end
            end

            MODE_SET_ALL:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (use_mask[i])
                    begin
                        if (cmd_reg.value)
                        begin
                            logical_next[i] = !later_peer[i];
                            armed_next[i]   = !later_peer[i] && cfg.pulse_len[i] != '0;
                            left_next[i]    = later_peer[i] ? '0 : cfg.pulse_len[i];
                            if (later_peer[i] || (logical_reg[i] && earlier_peer[i]))
                                pin_next[i] = cfg.active_low;
                        end
                        else
                        begin
                            logical_next[i] = 1'b0;
                            armed_next[i]   = 1'b0;
                            left_next[i]    = '0;
                        end
                        note_mask[i] = 1'b1;
                        note_vals[i] = cmd_reg.value;
                    end
                end
                batch_next    = 1'b0;
                stag_on_next  = 1'b1;
                stag_now_next = 1'b1;
            end

            MODE_BATCH_START:
            begin
                batch_next = 1'b1;
            end

            MODE_BATCH_END:
            begin
                if (batch_reg)
                begin
                    batch_next    = 1'b0;
                    stag_on_next  = 1'b1;
                    stag_now_next = 1'b1;
                end
            end

            default:
            begin
                accepted = 1'b1;
            end
        endcase

        rsp_next.accepted       = accepted;
        rsp_next.pin_levels     = pin_next;
        rsp_next.logical_states = logical_next;
        rsp_next.notify_mask    = note_mask;
        rsp_next.notify_values  = note_vals;
        rsp_next.save_request   = save_req;
        rsp_next.stagger_busy   = stag_on_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_vld_reg   <= 1'b0;
            rsp_vld_reg   <= 1'b0;
            logical_reg   <= '0;
            drive_reg     <= '0;
            pin_reg       <= '1;
            armed_reg     <= '0;
            left_reg      <= '0;
            batch_reg     <= 1'b0;
            stag_on_reg   <= 1'b0;
            stag_now_reg  <= 1'b0;
            stag_wait_reg <= '0;
            save_pend_reg <= 1'b0;
            save_wait_reg <= '0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
                cmd_vld_reg <= 1'b1;
            else if (fire)
                cmd_vld_reg <= 1'b0;

            if (fire)
                rsp_vld_reg <= 1'b1;
            else if (rsp_ready)
                rsp_vld_reg <= 1'b0;

            if (fire)
            begin
                logical_reg   <= logical_next;
                drive_reg     <= drive_next;
                pin_reg       <= pin_next;
                armed_reg     <= armed_next;
                left_reg      <= left_next;
                batch_reg     <= batch_next;
                stag_on_reg   <= stag_on_next;
                stag_now_reg  <= stag_now_next;
                stag_wait_reg <= stag_wait_next;
                save_pend_reg <= save_pend_next;
                save_wait_reg <= save_wait_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
            cmd_reg <= cmd;
        if (fire)
            rsp_reg <= rsp_next;
    end

endmodule

>>> rtl/relay_bank_interlock_pulse_stagger.sv
// Top level of the relay bank controller: configuration registers and command core.
//
// One command or millisecond tick is taken per clock cycle while the response
// channel takes results, with full throughput under continuous traffic. A
// transaction accepted on the command channel lands in a command register;
// once the result register is free, the single-pass update logic around the
// channel state registers produces its result into the result register, which
// offers it; the command register refills in the same cycle. The result register
// and command register together let a new transaction in while an earlier
// result waits on the response channel. Configuration is written through its
// own channel, which is always ready; write it only while no transaction is
// in flight.
module relay_bank_interlock_pulse_stagger
    import rbip_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmd_t                  cmd,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp
);

    cfg_t cfg;

    rbip_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rbip_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

>>> rtl/rbip_checker.sv
// Port-level checks on the relay bank controller, bound to the top level.
module rbip_checker
    import rbip_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_notify_within_mask: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.notify_values & ~rsp.notify_mask) == '0)
        else $error("notify value outside notify mask");

    a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.accepted |-> rsp.notify_mask == '0 && !rsp.save_request)
        else $error("rejected transaction had side effects");

    a_notify_on_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.notify_mask & ~rsp.notify_values & rsp.logical_states) == '0)
        else $error("channel notified off but reads on");

endmodule

bind relay_bank_interlock_pulse_stagger rbip_checker u_rbip_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

>>> tb/relay_bank_interlock_pulse_stagger_test.sv
// Self-checking testbench for the relay bank controller with its own response predictor.
`timescale 1ns / 1ps

module relay_bank_interlock_pulse_stagger_test
    import rbip_pkg::*;
;

    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         QUIET_TICKS  = 1020;

    class relay_scoreboard;
        cfg_t                settings;
        logic [CHANNELS-1:0] on_bits;
        logic [CHANNELS-1:0] drive_bits;
        logic [CHANNELS-1:0] pin_bits;
        logic [CHANNELS-1:0] armed_bits;
        logic [PULSE_W-1:0]  pulse_count [CHANNELS];
        logic                in_batch;
        logic                staggering;
        logic                stagger_first;
        logic [STAGGER_W-1:0] stagger_count;
        logic                save_due;
        logic [SAVE_W-1:0]   save_count;
        logic [CHANNELS-1:0] fired_mask;
        logic [CHANNELS-1:0] fired_vals;
        logic                save_now;
        rsp_t                expected_rsp [$];
        int                  errors;

        function new();
            settings.channel_count    = COUNT_W'(4);
            settings.active_low       = 1'b1;
            settings.stagger_interval = STAGGER_W'(100);
            settings.interlock_groups = '0;
            settings.pulse_len        = '0;
            on_bits       = '0;
            drive_bits    = '0;
            pin_bits      = '1;
            armed_bits    = '0;
            for (int i = 0; i < CHANNELS; i++) pulse_count[i] = '0;
            in_batch      = 1'b0;
            staggering    = 1'b0;
            stagger_first = 1'b0;
            stagger_count = '0;
            save_due      = 1'b0;
            save_count    = '0;
            errors        = 0;
        endfunction

        function void write_register(reg_idx_e idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_CHANNEL_COUNT:    settings.channel_count    = data[COUNT_W-1:0];
                REG_ACTIVE_LOW:       settings.active_low       = data[0];
                REG_STAGGER_INTERVAL: settings.stagger_interval = data[STAGGER_W-1:0];
                REG_INTERLOCK_GROUPS: settings.interlock_groups = data;
                REG_PULSE_LEN_0:      settings.pulse_len[0]     = data;
                REG_PULSE_LEN_1:      settings.pulse_len[1]     = data;
                REG_PULSE_LEN_2:      settings.pulse_len[2]     = data;
                REG_PULSE_LEN_3:      settings.pulse_len[3]     = data;
                default: ;
            endcase
        endfunction

        function int channels_in_use();
            if (settings.channel_count == 0 || settings.channel_count > CHANNELS)
                return CHANNELS;
            return int'(settings.channel_count);
        endfunction

        function logic [GROUP_W-1:0] group_number(int i);
            return settings.interlock_groups[GROUP_W*i +: GROUP_W];
        endfunction

        function void drive_output(int i, logic on);
            pin_bits[i] = on ^ settings.active_low;
        endfunction

        function void switch_channel(int idx, logic v);
            int                 n;
            logic [GROUP_W-1:0] g;
            n = channels_in_use();
            g = group_number(idx);
            if (!in_batch && on_bits[idx] == v && drive_bits[idx] == v) return;
            if (v && g != 0)
            begin
                for (int i = 0; i < n; i++)
                begin
                    if (i != idx && group_number(i) == g && on_bits[i])
                    begin
                        drive_output(i, 1'b0);
                        on_bits[i]     = 1'b0;
                        armed_bits[i]  = 1'b0;
                        pulse_count[i] = '0;
                    end
                end
            end
            if (!in_batch && !staggering)
            begin
                drive_output(idx, v);
                drive_bits[idx] = v;
            end
            on_bits[idx] = v;
            if (v && settings.pulse_len[idx] != 0)
            begin
                armed_bits[idx]  = 1'b1;
                pulse_count[idx] = settings.pulse_len[idx];
            end
            else
            begin
                armed_bits[idx]  = 1'b0;
                pulse_count[idx] = '0;
            end
            if (!in_batch)
            begin
                save_due   = 1'b1;
                save_count = SAVE_DELAY;
            end
            fired_mask[idx] = 1'b1;
            fired_vals[idx] = v;
        endfunction

        function void request_save();
            save_now = 1'b1;
            save_due = 1'b0;
        endfunction

        function void close_batch();
            if (!in_batch) return;
            in_batch      = 1'b0;
            staggering    = 1'b1;
            stagger_first = 1'b1;
        endfunction

        function void apply_tick();
            int   n;
            logic applied;
            logic waiting;
            n = channels_in_use();
            for (int i = 0; i < CHANNELS; i++)
                if (armed_bits[i] && pulse_count[i] != 0) pulse_count[i]--;
            if (stagger_count != 0) stagger_count--;
            if (save_count != 0) save_count--;
            if (staggering && (stagger_first || stagger_count == 0))
            begin
                applied = 1'b0;
                waiting = 1'b0;
                for (int i = 0; i < n; i++)
                begin
                    if (drive_bits[i] != on_bits[i])
                    begin
                        if (!applied)
                        begin
                            drive_output(i, on_bits[i]);
                            drive_bits[i] = on_bits[i];
                            stagger_first = 1'b0;
                            stagger_count = settings.stagger_interval;
                            applied       = 1'b1;
                        end
                        else
                        begin
                            waiting = 1'b1;
                        end
                    end
                end
                if (!applied && !waiting)
                begin
                    staggering = 1'b0;
                    request_save();
                end
            end
            if (!staggering && save_due && save_count == 0) request_save();
            for (int i = 0; i < n; i++)
            begin
                if (armed_bits[i] && pulse_count[i] == 0)
                begin
                    armed_bits[i] = 1'b0;
                    switch_channel(i, 1'b0);
                end
            end
        endfunction

        function rsp_t predict_response(cmd_t c);
            rsp_t r;
            int   n;
            int   ch;
            logic ok;
            n  = channels_in_use();
            ch = int'(c.channel);
            ok = 1'b1;
            fired_mask = '0;
            fired_vals = '0;
            save_now   = 1'b0;
            case (c.mode)
                MODE_TICK: apply_tick();
                MODE_SET, MODE_TOGGLE:
                begin
                    if (ch < 1 || ch > n) ok = 1'b0;
                    else if (c.mode == MODE_SET) switch_channel(ch - 1, c.value);
                    else switch_channel(ch - 1, ~on_bits[ch-1]);
                end
                MODE_SET_ALL:
                begin
                    in_batch = 1'b1;
                    for (int i = 0; i < n; i++) switch_channel(i, c.value);
                    close_batch();
                end
                MODE_BATCH_START: in_batch = 1'b1;
                MODE_BATCH_END:   close_batch();
                default: ;
            endcase
            r.accepted       = ok;
            r.pin_levels     = pin_bits;
            r.logical_states = on_bits;
            r.notify_mask    = fired_mask;
            r.notify_values  = fired_vals;
            r.save_request   = save_now;
            r.stagger_busy   = staggering;
            return r;
        endfunction

        function void note_command(cmd_t c);
            expected_rsp.push_back(predict_response(c));
        endfunction

        function void compare_field(string field, logic [3:0] want, logic [3:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %h actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: response expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_rsp.pop_front();
            compare_field("accepted", 4'(want.accepted), 4'(got.accepted));
            compare_field("pin_levels", want.pin_levels, got.pin_levels);
            compare_field("logical_states", want.logical_states, got.logical_states);
            compare_field("notify_mask", want.notify_mask, got.notify_mask);
            compare_field("notify_values", want.notify_values, got.notify_values);
            compare_field("save_request", 4'(want.save_request), 4'(got.save_request));
            compare_field("stagger_busy", 4'(want.stagger_busy), 4'(got.stagger_busy));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  cmd_valid;
    logic                  cmd_ready;
    cmd_t                  cmd;
    logic                  rsp_valid;
    logic                  rsp_ready;
    rsp_t                  rsp;

    relay_scoreboard sb;
    int              burst_left;
    int              issued;
    int              stall_left;
    int              stall_style;
    int              rx_cycles;
    int              idle_cycles;

    relay_bank_interlock_pulse_stagger i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready) sb.note_command(cmd);
            if (rsp_valid && rsp_ready) sb.check_response(rsp);
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("relay_bank_interlock_pulse_stagger_test: FAIL");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            rsp_ready <= 1'b1;
            case (stall_style)
                1: if ($urandom_range(0, 1) == 0) stall_left = 1;
                2: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 15);
                default: ;
            endcase
        end
        rx_cycles++;
        if (rx_cycles % 256 == 0) stall_style = $urandom_range(0, 2);
    end

    function cmd_t make_cmd(logic [2:0] m, int ch, logic v);
        cmd_t c;
        c.mode    = m;
        c.channel = CHAN_ID_W'(ch);
        c.value   = v;
        return c;
    endfunction

    function int pick_channel();
        if ($urandom_range(0, 4) != 0) return $urandom_range(1, sb.channels_in_use());
        return $urandom_range(0, 255);
    endfunction

    task automatic issue(cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                @(negedge clk);
                cmd_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= c;
        do @(posedge clk); while (!cmd_ready);
        burst_left--;
        issued++;
    endtask

    task automatic issue_ticks(int count);
        repeat (count)
            issue(make_cmd(MODE_TICK, $urandom_range(0, 255), 1'($urandom_range(0, 1))));
    endtask

    task automatic drain();
        if (cmd_valid)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
        end
        burst_left = 0;
        while (sb.expected_rsp.size() != 0) @(posedge clk);
    endtask

    task automatic write_register(reg_idx_e idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_register(idx, data);
    endtask

    task automatic load_settings(logic [2:0] count, logic low, logic [15:0] interval,
                                 logic [31:0] groups, logic [31:0] p0, logic [31:0] p1,
                                 logic [31:0] p2, logic [31:0] p3);
        drain();
        write_register(REG_CHANNEL_COUNT, 32'(count));
        write_register(REG_ACTIVE_LOW, 32'(low));
        write_register(REG_STAGGER_INTERVAL, 32'(interval));
        write_register(REG_INTERLOCK_GROUPS, groups);
        write_register(REG_PULSE_LEN_0, p0);
        write_register(REG_PULSE_LEN_1, p1);
        write_register(REG_PULSE_LEN_2, p2);
        write_register(REG_PULSE_LEN_3, p3);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function logic [31:0] small_groups();
        logic [31:0] g;
        for (int i = 0; i < CHANNELS; i++) g[8*i +: 8] = 8'($urandom_range(0, 2));
        return g;
    endfunction

    task automatic run_random(int items);
        int          target;
        int          k;
        logic [2:0]  m;
        target = issued + items;
        while (issued < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    m = ($urandom_range(0, 1) == 0) ? MODE_SET : MODE_TOGGLE;
                    issue(make_cmd(m, pick_channel(), 1'($urandom_range(0, 1))));
                end
                3, 4: issue_ticks($urandom_range(1, 6));
                5, 6:
                begin
                    issue(make_cmd(MODE_BATCH_START, pick_channel(),
                                   1'($urandom_range(0, 1))));
                    k = $urandom_range(1, 4);
                    repeat (k)
                    begin
                        m = ($urandom_range(0, 2) == 0) ? MODE_TOGGLE : MODE_SET;
                        issue(make_cmd(m, pick_channel(), 1'($urandom_range(0, 1))));
                    end
                    issue(make_cmd(MODE_BATCH_END, pick_channel(),
                                   1'($urandom_range(0, 1))));
                    issue_ticks($urandom_range(1, 8));
                end
                7:
                begin
                    issue(make_cmd(MODE_SET_ALL, pick_channel(), 1'($urandom_range(0, 1))));
                    issue_ticks($urandom_range(1, 6));
                end
                8: issue(make_cmd(3'($urandom_range(0, 7)), $urandom_range(0, 255),
                                  1'($urandom_range(0, 1))));
                default:
                begin
                    issue(make_cmd(MODE_SET, pick_channel(), 1'b1));
                    issue_ticks($urandom_range(1, 10));
                end
            endcase
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        cmd_valid   = 1'b0;
        cmd         = '0;
        rsp_ready   = 1'b0;
        burst_left  = 0;
        issued      = 0;
        stall_left  = 0;
        stall_style = 0;
        rx_cycles   = 0;
        idle_cycles = 0;
        sb          = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        load_settings(3'd4, 1'b0, 16'd2, 32'h0101_0202, 32'd3, 32'd0, 32'd0, 32'd0);
        issue(make_cmd(MODE_SET, 1, 1'b1));
        issue(make_cmd(MODE_SET, 1, 1'b1));
        issue(make_cmd(MODE_SET, 2, 1'b1));
        issue(make_cmd(MODE_TOGGLE, 2, 1'b0));
        issue(make_cmd(MODE_SET, 0, 1'b1));
        issue(make_cmd(MODE_TOGGLE, 5, 1'b0));
        issue(make_cmd(MODE_SET, 255, 1'b1));
        issue(make_cmd(MODE_SPARE_A, 255, 1'b1));
        issue(make_cmd(MODE_SPARE_B, 0, 1'b0));
        issue(make_cmd(MODE_BATCH_END, 1, 1'b0));
        issue(make_cmd(MODE_BATCH_START, 1, 1'b0));
        issue(make_cmd(MODE_SET, 3, 1'b1));
        issue(make_cmd(MODE_SET, 4, 1'b1));
        issue(make_cmd(MODE_BATCH_END, 1, 1'b0));
        issue_ticks(4);
        issue(make_cmd(MODE_SET_ALL, 0, 1'b1));
        issue_ticks(5);
        issue(make_cmd(MODE_SET_ALL, 0, 1'b0));

        load_settings(3'd0, 1'b1, 16'd0, 32'h0000_0000, 32'd0, 32'd1, 32'd0, 32'd2);
        run_random(120);
        load_settings(3'd7, 1'b0, 16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
                      32'hFFFF_FFFF, 32'd3);
        run_random(120);
        load_settings(3'd1, 1'b1, 16'd3, $urandom, $urandom_range(0, 6), 32'd0, 32'd0, 32'd0);
        run_random(120);
        load_settings(3'd3, 1'b0, 16'd1, 32'h0001_0100, 32'd0, 32'd4, 32'd0, 32'd0);
        run_random(120);
        issue(make_cmd(MODE_TOGGLE, 1, 1'b0));
        issue_ticks(QUIET_TICKS);
        load_settings(3'd2, 1'b1, 16'hFFFF, small_groups(), $urandom_range(0, 6),
                      $urandom_range(0, 6), 32'd0, 32'd0);
        run_random(120);
        load_settings(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                      16'($urandom_range(0, 5)),
                      small_groups(), $urandom_range(0, 6), $urandom_range(0, 6),
                      $urandom_range(0, 6), $urandom_range(0, 6));
        run_random(120);
        load_settings(3'd4, 1'b1, 16'd2, small_groups(), $urandom_range(0, 6),
                      $urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6));
        run_random(120);

        drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.expected_rsp.size() == 0)
            $display("relay_bank_interlock_pulse_stagger_test: PASS");
        else
            $display("relay_bank_interlock_pulse_stagger_test: FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/rbip_pkg.sv
rtl/rbip_cfg.sv
rtl/rbip_core.sv
rtl/relay_bank_interlock_pulse_stagger.sv
rtl/rbip_checker.sv
tb/relay_bank_interlock_pulse_stagger_test.sv
